// ----- rtl/button_gesture_detector_macros.svh -----
// ---------------------------------------------------------------------------
// Button gesture detector assertion macros
// Shorthand for clocked implication checks with a disable-iff reset guard.
// ---------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_DETECTOR_MACROS_SVH
`define BUTTON_GESTURE_DETECTOR_MACROS_SVH

// Same-cycle implication.
`define BGD_ASSERT_NOW(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("button gesture detector check failed");

// Next-cycle implication.
`define BGD_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("button gesture detector check failed");

`endif

// ----- rtl/bgd_pkg.sv -----
// ---------------------------------------------------------------------------
// bgd_pkg
// Shared types, codes and defaults of the button gesture detector.
// ---------------------------------------------------------------------------
package bgd_pkg;

   localparam int DEFAULT_BUTTONS    = 2;
   localparam int DEFAULT_TIMER_BITS = 16;
   localparam int LIMIT_W            = 16;
   localparam int CSR_IDX_W          = 3;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLICK_TIME        = 3'd0,
      CSR_HOLD_TIME         = 3'd1,
      CSR_REPEAT_CLICK_TIME = 3'd2,
      CSR_REPEAT_HOLD_TIME  = 3'd3,
      CSR_IDLE_TIME         = 3'd4
   } csr_index_type;

   localparam logic [LIMIT_W-1:0] RESET_CLICK_TIME        = 16'd30;
   localparam logic [LIMIT_W-1:0] RESET_HOLD_TIME         = 16'd100;
   localparam logic [LIMIT_W-1:0] RESET_REPEAT_CLICK_TIME = 16'd40;
   localparam logic [LIMIT_W-1:0] RESET_REPEAT_HOLD_TIME  = 16'd20;
   localparam logic [LIMIT_W-1:0] RESET_IDLE_TIME         = 16'd500;

   // Reported events
   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_PRESS       = 3'd1,
      EV_PRESS_DBL   = 3'd2,
      EV_RELEASE     = 3'd3,
      EV_CLICK       = 3'd4,
      EV_HOLD        = 3'd5,
      EV_CLICKS_OVER = 3'd6,
      EV_IDLE        = 3'd7
   } event_type;

   // Per-button mode; bit 0 is the contact level the mode implies
   typedef enum logic [1:0] {
      MODE_OPEN   = 2'd0,
      MODE_CLOSED = 2'd1,
      MODE_WAIT   = 2'd2,
      MODE_HOLD   = 2'd3
   } mode_type;

   localparam logic [1:0] CLICKS_ONE    = 2'd1;
   localparam logic [1:0] CLICKS_DOUBLE = 2'd2;
   localparam logic [1:0] CLICKS_MAX    = 2'd3;

   // Timing limits handed from the register file to every button
   typedef struct packed {
      logic [LIMIT_W-1:0] fast_limit;
      logic [LIMIT_W-1:0] hold_limit;
      logic [LIMIT_W-1:0] gap_limit;
      logic [LIMIT_W-1:0] repeat_limit;
      logic [LIMIT_W-1:0] idle_time;
   } cfg_type;

   // Per-button tick outcome
   typedef struct packed {
      event_type ev;
      logic      busy;
   } btn_status_type;

   function automatic logic [1:0] bump_clicks(input logic [1:0] cnt);
      return (cnt == CLICKS_MAX) ? cnt : cnt + 2'd1;
   endfunction

endpackage

// ----- rtl/bgd_csr.sv -----
// ---------------------------------------------------------------------------
// bgd_csr
// Timing limit registers; writes to unused indexes are dropped.
// ---------------------------------------------------------------------------
module bgd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bgd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bgd_pkg::LIMIT_W-1:0]       csr_wdata,
   output bgd_pkg::cfg_type                  cfg
);
   import bgd_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_limit   <= RESET_CLICK_TIME;
         cfg_ff.hold_limit   <= RESET_HOLD_TIME;
         cfg_ff.gap_limit    <= RESET_REPEAT_CLICK_TIME;
         cfg_ff.repeat_limit <= RESET_REPEAT_HOLD_TIME;
         cfg_ff.idle_time    <= RESET_IDLE_TIME;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLICK_TIME:        cfg_ff.fast_limit   <= csr_wdata;
            CSR_HOLD_TIME:         cfg_ff.hold_limit   <= csr_wdata;
            CSR_REPEAT_CLICK_TIME: cfg_ff.gap_limit    <= csr_wdata;
            CSR_REPEAT_HOLD_TIME:  cfg_ff.repeat_limit <= csr_wdata;
            CSR_IDLE_TIME:         cfg_ff.idle_time    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/bgd_button.sv -----
// ---------------------------------------------------------------------------
// bgd_button
// State of one button: mode, tick timer, click counter and busy flag.
// ---------------------------------------------------------------------------
module bgd_button #(
   parameter int TIMER_BITS = bgd_pkg::DEFAULT_TIMER_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    contact,
   input  bgd_pkg::cfg_type        cfg,
   output bgd_pkg::btn_status_type status
);
   import bgd_pkg::*;

   localparam int CMP_W = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;

   mode_type              mode_ff,   mode_in;
   logic [TIMER_BITS-1:0] tick_ff,   tick_in;
   logic                  run_ff,    run_in;
   logic [1:0]            clicks_ff, clicks_in;
   logic                  busy_ff,   busy_in;

   logic [TIMER_BITS-1:0] tick_up;
   logic                  same;
   logic                  idle_hit, over_hit, enter_hold, rep_hold, fast_click;
   event_type             ev;

   function automatic logic reached(input logic [TIMER_BITS-1:0] t,
                                    input logic [LIMIT_W-1:0] lim);
      return CMP_W'(t) >= CMP_W'(lim);
   endfunction

   // Timer counts first, saturating
   assign tick_up = (run_ff && (tick_ff != {TIMER_BITS{1'b1}})) ? tick_ff + 1'b1 : tick_ff;
   assign same    = (contact == mode_ff[0]);

   assign idle_hit   = same && run_ff && (mode_ff == MODE_OPEN) &&
                       reached(tick_up, cfg.idle_time);
   assign over_hit   = same && run_ff && (mode_ff == MODE_WAIT) &&
                       reached(tick_up, cfg.gap_limit);
   assign enter_hold = same && run_ff && (mode_ff == MODE_CLOSED) &&
                       reached(tick_up, cfg.hold_limit);
   // A zero repeat limit also fires a repeat hold step in the same tick as hold entry
   assign rep_hold   = (same && run_ff && (mode_ff == MODE_HOLD) &&
                        reached(tick_up, cfg.repeat_limit)) ||
                       (enter_hold && (cfg.repeat_limit == '0));
   assign fast_click = (mode_ff == MODE_CLOSED) &&
                       (!reached(tick_up, cfg.fast_limit) ||
                        ((clicks_ff < CLICKS_DOUBLE) && !reached(tick_up, cfg.hold_limit)));

   // Next state
   always_comb begin
      mode_in   = mode_ff;
      tick_in   = tick_up;
      run_in    = run_ff;
      clicks_in = clicks_ff;
      busy_in   = busy_ff;
      if (!same) begin
         tick_in = '0;
         run_in  = 1'b1;
         busy_in = 1'b1;
         if (contact) begin
            mode_in = MODE_CLOSED;
         end else begin
            case (mode_ff)
               MODE_CLOSED: begin
                  if (fast_click) begin
                     mode_in   = MODE_WAIT;
                     clicks_in = bump_clicks(clicks_ff);
                  end else begin
                     mode_in   = MODE_OPEN;
                     clicks_in = '0;
                  end
               end
               MODE_HOLD: begin
                  mode_in   = MODE_OPEN;
                  clicks_in = '0;
               end
               default: mode_in = MODE_OPEN;
            endcase
         end
      end else begin
         if (idle_hit) begin
            run_in  = 1'b0;
            busy_in = 1'b0;
         end
         if (over_hit) begin
            mode_in   = MODE_OPEN;
            clicks_in = '0;
         end
         if (enter_hold) begin
            mode_in   = MODE_HOLD;
            clicks_in = CLICKS_ONE;
            tick_in   = '0;
            run_in    = 1'b1;
         end
         if (rep_hold) begin
            mode_in   = MODE_HOLD;
            clicks_in = bump_clicks(enter_hold ? CLICKS_ONE : clicks_ff);
            tick_in   = '0;
            run_in    = 1'b1;
         end
      end
   end

   // Event of this tick
   always_comb begin
      ev = EV_NONE;
      if (!same) begin
         if (contact) begin
            ev = (clicks_ff == CLICKS_DOUBLE) ? EV_PRESS_DBL : EV_PRESS;
         end else begin
            ev = fast_click ? EV_CLICK : EV_RELEASE;
         end
      end else if (enter_hold || rep_hold) begin
         ev = EV_HOLD;
      end else if (over_hit) begin
         ev = EV_CLICKS_OVER;
      end else if (idle_hit) begin
         ev = EV_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_OPEN;
         tick_ff   <= '0;
         run_ff    <= 1'b1;
         clicks_ff <= '0;
         busy_ff   <= 1'b1;
      end else if (advance) begin
         mode_ff   <= mode_in;
         tick_ff   <= tick_in;
         run_ff    <= run_in;
         clicks_ff <= clicks_in;
         busy_ff   <= busy_in;
      end
   end

   assign status.ev   = ev;
   assign status.busy = busy_in;

endmodule

// ----- rtl/button_gesture_detector.sv -----
// ---------------------------------------------------------------------------
// button_gesture_detector
// Per-button click, double click, hold and idle detection on sampled ticks.
// ---------------------------------------------------------------------------
// Each request word is one tick carrying the contact level of every button;
// each tick yields exactly one response word in the cycle after it is taken.
// A new tick is accepted every cycle: the per-button update is a single
// compare-and-update pass feeding the response register, and req_ready only
// drops while that register holds a word the consumer has not taken. The
// response carries the event of the highest-numbered button that had one
// (event code 0 with button 0 when nothing happened) and one sleep bit per
// button, set when that button has gone idle. Timing limits sit in five
// 16-bit registers written through csr_we/csr_index/csr_wdata; write them
// only while no tick is in flight. Indexes past the last register are
// ignored.
// ---------------------------------------------------------------------------
module button_gesture_detector #(
   parameter int BUTTONS    = bgd_pkg::DEFAULT_BUTTONS,
   parameter int TIMER_BITS = bgd_pkg::DEFAULT_TIMER_BITS,
   parameter int BTN_IDX_W  = (BUTTONS > 1) ? $clog2(BUTTONS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   // Tick input
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [BUTTONS-1:0]            req_contacts,
   // Event output
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_event_res,
   output logic [BTN_IDX_W-1:0]          rsp_event_button,
   output logic [BUTTONS-1:0]            rsp_sleep_allowed,
   // Register writes
   input  logic                          csr_we,
   input  logic [bgd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bgd_pkg::LIMIT_W-1:0]   csr_wdata
);
   import bgd_pkg::*;

   cfg_type              cfg;
   btn_status_type       status [BUTTONS];
   logic                 req_fire;

   event_type            ev_sel;
   logic [BTN_IDX_W-1:0] btn_sel;
   logic [BUTTONS-1:0]   sleep_sel;

   logic                 rsp_valid_ff;
   event_type            rsp_event_ff, rsp_event_in;
   logic [BTN_IDX_W-1:0] rsp_button_ff, rsp_button_in;
   logic [BUTTONS-1:0]   rsp_sleep_ff, rsp_sleep_in;

   // Take a tick whenever the response register is free or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   bgd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // One state slice per button, all advanced by the same accepted tick
   for (genvar b = 0; b < BUTTONS; b++) begin : g_button
      bgd_button #(
         .TIMER_BITS (TIMER_BITS)
      ) u_button (
         .clock   (clock),
         .reset   (reset),
         .advance (req_fire),
         .contact (req_contacts[b]),
         .cfg     (cfg),
         .status  (status[b])
      );
   end

   // Highest-numbered button with an event wins; sleep is the inverse of busy
   always_comb begin
      ev_sel    = EV_NONE;
      btn_sel   = '0;
      sleep_sel = '0;
      for (int b = 0; b < BUTTONS; b++) begin
         if (status[b].ev != EV_NONE) begin
            ev_sel  = status[b].ev;
            btn_sel = BTN_IDX_W'(b);
         end
         sleep_sel[b] = !status[b].busy;
      end
   end

   // Load the response register on a taken tick, hold it otherwise
   assign rsp_event_in  = req_fire ? ev_sel    : rsp_event_ff;
   assign rsp_button_in = req_fire ? btn_sel   : rsp_button_ff;
   assign rsp_sleep_in  = req_fire ? sleep_sel : rsp_sleep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_event_ff  <= rsp_event_in;
      rsp_button_ff <= rsp_button_in;
      rsp_sleep_ff  <= rsp_sleep_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = rsp_event_ff;
   assign rsp_event_button  = rsp_button_ff;
   assign rsp_sleep_allowed = rsp_sleep_ff;

endmodule

// ----- rtl/bgd_checker.sv -----
// ---------------------------------------------------------------------------
// bgd_checker
// Port-level checks of the button gesture detector, bound to the top level.
// ---------------------------------------------------------------------------
`include "button_gesture_detector_macros.svh"

module bgd_checker #(
   parameter int BUTTONS   = bgd_pkg::DEFAULT_BUTTONS,
   parameter int BTN_IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [2:0]           rsp_event_res,
   input logic [BTN_IDX_W-1:0] rsp_event_button,
   input logic [BUTTONS-1:0]   rsp_sleep_allowed
);
   import bgd_pkg::*;

   // A stalled word holds
   `BGD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_event_res) && $stable(rsp_event_button) && $stable(rsp_sleep_allowed))

   // Every taken tick shows up as a response word next cycle
   `BGD_ASSERT_NEXT(a_tick_to_rsp, clock, reset, req_valid && req_ready, rsp_valid)

   // An empty output stage never blocks the input
   `BGD_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // An EV_NONE word reports button zero
   `BGD_ASSERT_NOW(a_none_button, clock, reset, rsp_valid && (rsp_event_res == EV_NONE),
      rsp_event_button == '0)

   // An idle event leaves its button asleep
   `BGD_ASSERT_NOW(a_idle_sleep, clock, reset, rsp_valid && (rsp_event_res == EV_IDLE),
      rsp_sleep_allowed[rsp_event_button])

endmodule

bind button_gesture_detector bgd_checker #(
   .BUTTONS   (BUTTONS),
   .BTN_IDX_W (BTN_IDX_W)
) u_bgd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_event_res     (rsp_event_res),
   .rsp_event_button  (rsp_event_button),
   .rsp_sleep_allowed (rsp_sleep_allowed)
);
